// File: sv/mcfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfa_pkg: shared types and constants of the multi-camera frame aligner
// Queue geometry, status codes, register indexes and the frame entry type.
// ----------------------------------------------------------------------------
package mcfa_pkg;

    localparam int CAMERAS     = 4;
    localparam int QUEUE_DEPTH = 3;
    localparam int CAM_W       = $clog2(CAMERAS);
    localparam int POS_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W       = 3;
    localparam int ENTRIES     = CAMERAS * QUEUE_DEPTH;
    localparam int ADDR_W      = $clog2(ENTRIES);
    localparam int ENTRY_W     = 64 + 32 + 32;

    localparam logic [63:0] DEFAULT_TOLERANCE = 64'd33333333;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_TOL   = 2'd3;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [63:0] REG_CAMERA_COUNT = 64'd0;
    localparam logic [63:0] REG_TOLERANCE    = 64'd1;

    typedef struct packed {
        logic [63:0] stamp;
        logic [31:0] sequence_num;
        logic [31:0] tag;
    } entry_t;

    // Flat memory address of one queue slot.
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [CAM_W-1:0] cam,
                                                    input logic [POS_W-1:0] pos);
        logic [ADDR_W+7:0] a;
        a = (ADDR_W + 8)'(cam) * (ADDR_W + 8)'(QUEUE_DEPTH) + (ADDR_W + 8)'(pos);
        return a[ADDR_W-1:0];
    endfunction

endpackage

// File: sv/multi_camera_frame_aligner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_camera_frame_aligner: timestamp frame sync over per-camera queues
// Pushes frames into small per-camera queues held in one RAM; a pop finds an
// aligned set nearest the latest head timestamp and emits it camera by camera.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tuser: op; s_tdata: cam, seq, stamp, tag
//  m_      | out | m_tvalid/m_tready  | m_tdata, m_tuser (status), m_tlast
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  A push writes the new frame and returns a status; into a full queue it
//  first drops the oldest entry (two slot moves, a RAM read and a write each).
//  A pop reads each camera's head for the anchor, then each stored entry
//  through the single RAM port and the one distance unit, then emits each
//  camera's pick and closes the gap behind it.
//  Reset (aresetn low, synchronous) empties every queue and restores registers;
//  s_tready stays low until the whole transaction, including the queue shift
//  after its last result, is done, also while m_ stalls.
// ----------------------------------------------------------------------------
module multi_camera_frame_aligner (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation
    input  logic         s_tuser,
    // source_cam[31:0], frame_sequence[63:32], frame_timestamp[127:64],
    // frame_tag[159:128]
    input  logic [159:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_camera[1:0], out_sequence[33:2], out_timestamp[97:34],
    // out_tag[129:98], zero pad to 136
    output logic [135:0] m_tdata,
    // status[1:0]
    output logic [1:0]   m_tuser,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [63:0]  cfg_index,
    input  logic [63:0]  cfg_data
);
    import mcfa_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PSHRD  = 4'd1;  // read slot k+1
    localparam logic [3:0] S_PSHWR  = 4'd2;  // write it to slot k
    localparam logic [3:0] S_PSHNEW = 4'd3;  // write new frame
    localparam logic [3:0] S_HEADRD = 4'd4;  // read head of camera
    localparam logic [3:0] S_HEADCK = 4'd5;  // fold into anchor
    localparam logic [3:0] S_SRCHRD = 4'd6;  // read entry for distance
    localparam logic [3:0] S_SRCHD  = 4'd7;  // distance in flight
    localparam logic [3:0] S_SRCHCK = 4'd8;  // compare
    localparam logic [3:0] S_EMITRD = 4'd9;  // read pick
    localparam logic [3:0] S_EMITWT = 4'd10; // present result
    localparam logic [3:0] S_RMRD   = 4'd11; // shift remaining entries
    localparam logic [3:0] S_RMWR   = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13; // single status result

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [63:0]       tol_reg, tol_next;
    logic [FILL_W-1:0] fill_reg [CAMERAS];
    logic [FILL_W-1:0] fill_next [CAMERAS];
    logic [CAM_W-1:0]  cam_reg, cam_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  sel_reg, sel_next;
    logic [POS_W-1:0]  pick_reg [CAMERAS];
    logic [POS_W-1:0]  pick_next [CAMERAS];
    logic [63:0]       anchor_reg, anchor_next;
    logic [63:0]       best_reg, best_next;
    entry_t            new_reg, new_next;
    logic [1:0]        status_reg, status_next;
    entry_t            outent_reg, outent_next;
    logic              olast_reg, olast_next;

    logic              we;
    logic [ADDR_W-1:0] addr;
    entry_t            wdata, rdata;
    logic [63:0]       diff;
    entry_t            out_ent;

    logic [CAMERAS-1:0] empty_vec;
    logic               any_empty;

    mcfa_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    mcfa_dist u_dist (
        .aclk (aclk),
        .a    (rdata.stamp),
        .b    (anchor_reg),
        .diff (diff)
    );

    // Result payload of the emit state comes straight from RAM read data;
    // the address holds on the pick while the result waits.
    assign out_ent   = (state_reg == S_EMITWT) ? rdata : outent_reg;
    assign cfg_ready = (state_reg == S_IDLE);
    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign m_tvalid  = (state_reg == S_EMITWT) || (state_reg == S_OUT);
    assign m_tuser   = status_reg;
    assign m_tlast   = olast_reg;
    assign m_tdata   = {6'd0, out_ent.tag, out_ent.stamp,
                        out_ent.sequence_num, cam_reg};

    always_comb begin
        for (int c = 0; c < CAMERAS; c++) begin
            empty_vec[c] = (CNT_W'(c) < count_reg) && (fill_reg[c] == '0);
        end
        any_empty = |empty_vec;
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        tol_next    = tol_reg;
        fill_next   = fill_reg;
        cam_next    = cam_reg;
        pos_next    = pos_reg;
        sel_next    = sel_reg;
        pick_next   = pick_reg;
        anchor_next = anchor_reg;
        best_next   = best_reg;
        new_next    = new_reg;
        status_next = status_reg;
        outent_next = outent_reg;
        olast_next  = olast_reg;
        we          = 1'b0;
        addr        = slot_addr(cam_reg, pos_reg);
        wdata       = rdata;

        unique case (state_reg)
            S_IDLE: begin
                if (cfg_valid) begin
                    // clamp camera count and default a zero tolerance
                    if (cfg_index == REG_CAMERA_COUNT) begin
                        count_next = (cfg_data[2:0] == '0 ||
                                      cfg_data[2:0] > CNT_W'(CAMERAS))
                                     ? CNT_W'(CAMERAS) : cfg_data[2:0];
                    end else if (cfg_index == REG_TOLERANCE) begin
                        tol_next = (cfg_data == '0) ? DEFAULT_TOLERANCE : cfg_data;
                    end
                end else if (s_tvalid) begin
                    outent_next = '0;
                    olast_next  = 1'b1;
                    cam_next    = '0;
                    pos_next    = '0;
                    if (s_tuser == OP_PUSH) begin
                        new_next.sequence_num = s_tdata[63:32];
                        new_next.stamp        = s_tdata[127:64];
                        new_next.tag          = s_tdata[159:128];
                        if (s_tdata[31:0] >= 32'(count_reg)) begin
                            status_next = ST_RANGE;
                            state_next  = S_OUT;
                        end else begin
                            cam_next    = s_tdata[CAM_W-1:0];
                            status_next = ST_OK;
                            // drop the oldest when full: shift slots down
                            if (fill_reg[s_tdata[CAM_W-1:0]] == FILL_W'(QUEUE_DEPTH)
                                && QUEUE_DEPTH > 1) begin
                                pos_next   = '0;
                                state_next = S_PSHRD;
                            end else begin
                                state_next = S_PSHNEW;
                            end
                        end
                    end else begin
                        anchor_next = '0;
                        if (any_empty) begin
                            status_next = ST_EMPTY;
                            state_next  = S_OUT;
                        end else begin
                            status_next = ST_OK;
                            state_next  = S_HEADRD;
                        end
                    end
                end
            end
            S_PSHRD: begin
                addr       = slot_addr(cam_reg, pos_reg + POS_W'(1));
                state_next = S_PSHWR;
            end
            S_PSHWR: begin
                we    = 1'b1;
                addr  = slot_addr(cam_reg, pos_reg);
                wdata = rdata;
                if (32'(pos_reg) + 32'd2 >= 32'(QUEUE_DEPTH)) begin
                    fill_next[cam_reg] = FILL_W'(QUEUE_DEPTH - 1);
                    state_next         = S_PSHNEW;
                end else begin
                    pos_next   = pos_reg + POS_W'(1);
                    state_next = S_PSHRD;
                end
            end
            S_PSHNEW: begin
                we    = 1'b1;
                addr  = slot_addr(cam_reg, fill_reg[cam_reg] == FILL_W'(QUEUE_DEPTH)
                                  ? POS_W'(QUEUE_DEPTH - 1)
                                  : POS_W'(fill_reg[cam_reg]));
                wdata = new_reg;
                if (fill_reg[cam_reg] != FILL_W'(QUEUE_DEPTH)) begin
                    fill_next[cam_reg] = fill_reg[cam_reg] + FILL_W'(1);
                end
                // the push status carries camera zero
                cam_next   = '0;
                state_next = S_OUT;
            end
            S_HEADRD: begin
                addr       = slot_addr(cam_reg, '0);
                state_next = S_HEADCK;
            end
            S_HEADCK: begin
                if (rdata.stamp > anchor_reg) begin
                    anchor_next = rdata.stamp;
                end
                if (CNT_W'(cam_reg) + CNT_W'(1) >= count_reg) begin
                    cam_next   = '0;
                    pos_next   = '0;
                    sel_next   = '0;
                    state_next = S_SRCHRD;
                end else begin
                    cam_next   = cam_reg + CAM_W'(1);
                    state_next = S_HEADRD;
                end
            end
            S_SRCHRD: begin
                addr       = slot_addr(cam_reg, pos_reg);
                state_next = S_SRCHD;
            end
            S_SRCHD: begin
                state_next = S_SRCHCK;
            end
            S_SRCHCK: begin
                // ties keep the older entry
                if (pos_reg == '0 || diff < best_reg) begin
                    best_next = diff;
                    sel_next  = pos_reg;
                end
                if (FILL_W'(pos_reg) + FILL_W'(1) < fill_reg[cam_reg]) begin
                    pos_next   = pos_reg + POS_W'(1);
                    state_next = S_SRCHRD;
                end else if (((pos_reg == '0) ? diff :
                              ((diff < best_reg) ? diff : best_reg)) > tol_reg) begin
                    status_next = ST_TOL;
                    cam_next    = '0;
                    state_next  = S_OUT;
                end else begin
                    pick_next[cam_reg] = (pos_reg == '0 || diff < best_reg)
                                         ? pos_reg : sel_reg;
                    if (CNT_W'(cam_reg) + CNT_W'(1) >= count_reg) begin
                        cam_next   = '0;
                        state_next = S_EMITRD;
                    end else begin
                        cam_next   = cam_reg + CAM_W'(1);
                        pos_next   = '0;
                        state_next = S_SRCHRD;
                    end
                end
            end
            S_EMITRD: begin
                addr       = slot_addr(cam_reg, pick_reg[cam_reg]);
                olast_next = (CNT_W'(cam_reg) + CNT_W'(1) == count_reg);
                state_next = S_EMITWT;
            end
            S_EMITWT: begin
                // hold the pick on the read port while the result waits
                addr       = slot_addr(cam_reg, pick_reg[cam_reg]);
                olast_next = (CNT_W'(cam_reg) + CNT_W'(1) == count_reg);
                if (state_reg == S_EMITWT && m_tready) begin
                    pos_next   = pick_reg[cam_reg];
                    state_next = S_RMRD;
                end
            end
            S_RMRD: begin
                // close the gap left by the pick
                if (FILL_W'(pos_reg) + FILL_W'(1) < fill_reg[cam_reg]) begin
                    addr       = slot_addr(cam_reg, pos_reg + POS_W'(1));
                    state_next = S_RMWR;
                end else begin
                    fill_next[cam_reg] = fill_reg[cam_reg] - FILL_W'(1);
                    if (CNT_W'(cam_reg) + CNT_W'(1) >= count_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        cam_next   = cam_reg + CAM_W'(1);
                        state_next = S_EMITRD;
                    end
                end
            end
            S_RMWR: begin
                we         = 1'b1;
                addr       = slot_addr(cam_reg, pos_reg);
                wdata      = rdata;
                pos_next   = pos_reg + POS_W'(1);
                state_next = S_RMRD;
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= CNT_W'(CAMERAS);
            tol_reg   <= DEFAULT_TOLERANCE;
            for (int c = 0; c < CAMERAS; c++) begin
                fill_reg[c] <= '0;
            end
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            tol_reg   <= tol_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        cam_reg    <= cam_next;
        pos_reg    <= pos_next;
        sel_reg    <= sel_next;
        pick_reg   <= pick_next;
        anchor_reg <= anchor_next;
        best_reg   <= best_next;
        new_reg    <= new_next;
        status_reg <= status_next;
        olast_reg  <= olast_next;
        outent_reg <= outent_next;
    end

endmodule

// File: sv/mcfa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfa_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module mcfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: sv/mcfa_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfa_dist: shared distance unit
// Absolute difference of two timestamps, registered.
// ----------------------------------------------------------------------------
module mcfa_dist (
    input  logic        aclk,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] diff
);
    logic [63:0] diff_reg, diff_next;

    always_comb begin
        diff_next = (a > b) ? (a - b) : (b - a);
    end

    always_ff @(posedge aclk) begin
        diff_reg <= diff_next;
    end

    assign diff = diff_reg;
endmodule
